// File: design/lcrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Longest consecutive run tracker: shared package
// Word types, controller command and status records, and table constants.
// ----------------------------------------------------------------------------
package lcrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int MAX_PROBES_DEF    = 16;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam logic [31:0] KEY_MIN   = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX   = 32'h7fff_ffff;
    localparam logic [10:0] OUT_MAX   = 11'd2047;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               start_set;
    } t_in;

    typedef struct packed {
        logic [10:0] longest_run;
        logic        was_duplicate;
        logic        table_full;
    } t_out;

    // Which key a table walk searches for.
    typedef enum logic [2:0] {
        WALK_SELF  = 3'd0,
        WALK_LEFT  = 3'd1,
        WALK_RIGHT = 3'd2,
        WALK_LOW   = 3'd3,
        WALK_UP    = 3'd4
    } t_walk;

    // Which table entry is written.
    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_SELF = 2'd1,
        WR_LOW  = 2'd2,
        WR_UP   = 2'd3
    } t_wr;

    typedef struct packed {
        logic  accept;
        logic  clr_step;
        logic  walk_start;
        t_walk walk_kind;
        logic  probe_start;
        logic  probe_run;
        t_wr   wr_sel;
        logic  best_update;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic walk_done;
        logic self_hit;
        logic self_full;
        logic key_min;
        logic key_max;
        logic lleft_nz;
        logic lright_nz;
        logic low_write;
        logic up_write;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: design/longest_consecutive_run_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Longest consecutive run tracker
// Adds signed 32-bit values to a hashed set and reports the longest run of
// consecutive integers seen since the last start.
// ----------------------------------------------------------------------------
// One input word is taken at a time and answered by one result word. After
// reset the block sweeps the table memory before it takes its first word; a
// word with start_set high costs the same sweep before its value is inserted.
// Each table walk hashes its key to a home slot and then probes slots from
// there, one table memory read per cycle. A duplicate or a dropped value
// takes one walk; a new value takes up to five walks (itself, both
// neighbors, and both far run ends) plus up to three table writes. The
// result word is registered, so the next word is accepted while it waits
// to be taken.
// ----------------------------------------------------------------------------
module longest_consecutive_run_tracker_top #(
    parameter int TABLE_ENTRIES = lcrt_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PROBES    = lcrt_pkg::MAX_PROBES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lcrt_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output lcrt_pkg::t_out o_data
);
    import lcrt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lcrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_start_set(i_data.start_set),
        .o_stall    (o_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    lcrt_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_PROBES   (MAX_PROBES)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_data (i_data),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_data (o_data),
        .o_valid(o_valid),
        .i_stall(i_stall)
    );

endmodule
`default_nettype wire

// File: design/lcrt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: design/lcrt_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Home slot hash
// Four-stage pipeline: multiplicative hash, fold, then reduction modulo the
// table size by a reciprocal multiply with one correcting subtract.
// ----------------------------------------------------------------------------
module lcrt_hash #(
    parameter int TABLE_ENTRIES = lcrt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [31:0]                      i_key,
    output logic                             o_done,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_slot
);
    import lcrt_pkg::*;

    localparam int          SLOT_W  = $clog2(TABLE_ENTRIES);
    localparam logic [31:0] DIVISOR = 32'(TABLE_ENTRIES);
    localparam logic [31:0] RECIP   = 32'(64'h1_0000_0000 / 64'(TABLE_ENTRIES));

    logic [3:0]        r_vld;
    logic [31:0]       r_p1;
    logic [31:0]       r_h2;
    logic [31:0]       r_q;
    logic [31:0]       r_h3;
    logic [31:0]       r_qd;
    logic [SLOT_W-1:0] r_slot;

    logic [31:0] p1;
    logic [31:0] h2;
    logic [63:0] prod2;
    logic [31:0] qd;
    logic [31:0] diff;
    logic [31:0] rem;

    assign p1    = i_key * HASH_MULT;
    assign h2    = r_p1 ^ (r_p1 >> 16);
    assign prod2 = 64'(h2) * 64'(RECIP);
    assign qd    = r_q * DIVISOR;
    assign diff  = r_h3 - r_qd;
    // The estimated quotient is low by at most one, so one subtract finishes.
    assign rem   = (diff >= DIVISOR) ? (diff - DIVISOR) : diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= p1;
        r_h2   <= h2;
        r_q    <= prod2[63:32];
        r_h3   <= r_h2;
        r_qd   <= qd;
        r_slot <= SLOT_W'(rem);
    end

    assign o_done = r_vld[3];
    assign o_slot = r_slot;

`ifndef ASSERT_OFF
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (rem < DIVISOR))
        else $error("hash remainder not reduced below the table size");
`endif

endmodule
`default_nettype wire

// File: design/lcrt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Run tracker datapath
// Hash table memory, probe walker, run length arithmetic, longest run and
// the output word register.
// ----------------------------------------------------------------------------
module lcrt_dp #(
    parameter int TABLE_ENTRIES = lcrt_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PROBES    = lcrt_pkg::MAX_PROBES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lcrt_pkg::t_in  i_data,
    input  lcrt_pkg::t_cmd i_cmd,
    output lcrt_pkg::t_stat o_stat,
    output lcrt_pkg::t_out o_data,
    output logic           o_valid,
    input  logic           i_stall
);
    import lcrt_pkg::*;

    localparam int SLOT_W    = $clog2(TABLE_ENTRIES);
    localparam int LEN_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W   = 1 + 32 + LEN_W;
    localparam int PROBE_LIM = (MAX_PROBES < TABLE_ENTRIES) ? MAX_PROBES : TABLE_ENTRIES;
    localparam int CNT_W     = $clog2(PROBE_LIM + 1);
    localparam int CMP_W     = (LEN_W > 11) ? LEN_W : 11;

    // Item and walk registers
    t_in               r_item;
    logic [31:0]       r_key;
    logic [SLOT_W-1:0] r_pr_addr;
    logic [SLOT_W-1:0] r_chk_addr;
    logic              r_inflight;
    logic [CNT_W-1:0]  r_chk_cnt;

    // Walk results
    logic              r_self_hit;
    logic              r_self_full;
    logic [SLOT_W-1:0] r_self_slot;
    logic [LEN_W-1:0]  r_lleft;
    logic [LEN_W-1:0]  r_lright;
    logic              r_low_hit;
    logic [SLOT_W-1:0] r_low_slot;
    logic              r_up_hit;
    logic [SLOT_W-1:0] r_up_slot;

    logic [SLOT_W-1:0] r_clr_addr;
    logic [LEN_W-1:0]  r_best;
    t_out              r_out;
    logic              r_out_valid;

    logic [31:0]        item_key;
    logic [31:0]        key_sel;
    logic               hash_done;
    logic [SLOT_W-1:0]  home_slot;
    logic [SLOT_W-1:0]  pr_next;
    logic [SLOT_W-1:0]  clr_next;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    logic               rd_valid;
    logic [31:0]        rd_key;
    logic [LEN_W-1:0]   rd_len;
    logic               e_free;
    logic               e_hit;
    logic               e_exh;
    logic               walk_done;
    logic [LEN_W-1:0]   total;
    logic [CMP_W-1:0]   best_ext;
    logic [10:0]        best_sat;
    logic               out_free;

    assign item_key = r_item.item_value;
    assign total    = r_lleft + r_lright + LEN_W'(1);

    always_comb begin
        case (i_cmd.walk_kind)
            WALK_SELF:  key_sel = item_key;
            WALK_LEFT:  key_sel = item_key - 32'd1;
            WALK_RIGHT: key_sel = item_key + 32'd1;
            WALK_LOW:   key_sel = item_key - 32'(r_lleft);
            WALK_UP:    key_sel = item_key + 32'(r_lright);
            default:    key_sel = item_key;
        endcase
    end

    lcrt_hash #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.walk_start),
        .i_key  (key_sel),
        .o_done (hash_done),
        .o_slot (home_slot)
    );

    assign pr_next  = (r_pr_addr == SLOT_W'(TABLE_ENTRIES - 1)) ? '0
                                                                : r_pr_addr + SLOT_W'(1);
    assign clr_next = (r_clr_addr == SLOT_W'(TABLE_ENTRIES - 1)) ? '0
                                                                 : r_clr_addr + SLOT_W'(1);

    // Table writes: clearing pass, new key, and the two run endpoints.
    assign wr_en = i_cmd.clr_step || (i_cmd.wr_sel != WR_NONE);

    always_comb begin
        wr_addr = r_clr_addr;
        wr_data = '0;
        case (i_cmd.wr_sel)
            WR_SELF: begin
                wr_addr = r_self_slot;
                wr_data = {1'b1, item_key, total};
            end
            WR_LOW: begin
                wr_addr = r_low_slot;
                wr_data = {1'b1, item_key - 32'(r_lleft), total};
            end
            WR_UP: begin
                wr_addr = r_up_slot;
                wr_data = {1'b1, item_key + 32'(r_lright), total};
            end
            default: begin
                wr_addr = r_clr_addr;
                wr_data = '0;
            end
        endcase
    end

    lcrt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (i_cmd.probe_run),
        .i_rd_addr(r_pr_addr),
        .o_rd_data(rd_data)
    );

    assign rd_valid = rd_data[ENTRY_W-1];
    assign rd_key   = rd_data[LEN_W +: 32];
    assign rd_len   = rd_data[LEN_W-1:0];

    // A read is issued every cycle of a walk; the slot read in the previous cycle
    // is judged now, so a read past the final slot of the walk is simply ignored.
    assign e_free    = !rd_valid;
    assign e_hit     = rd_valid && (rd_key == r_key);
    assign e_exh     = !e_free && !e_hit && (r_chk_cnt == CNT_W'(PROBE_LIM - 1));
    assign walk_done = r_inflight && (e_free || e_hit || e_exh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
        end else if (i_cmd.probe_start) begin
            r_inflight <= 1'b0;
        end else if (i_cmd.probe_run) begin
            r_inflight <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item    <= i_data;
            r_lleft   <= '0;
            r_lright  <= '0;
            r_low_hit <= 1'b0;
            r_up_hit  <= 1'b0;
        end
        if (i_cmd.walk_start) begin
            r_key <= key_sel;
        end
        if (i_cmd.probe_start) begin
            r_pr_addr <= home_slot;
            r_chk_cnt <= '0;
        end else if (i_cmd.probe_run) begin
            r_pr_addr  <= pr_next;
            r_chk_addr <= r_pr_addr;
            if (r_inflight && !walk_done) begin
                r_chk_cnt <= r_chk_cnt + CNT_W'(1);
            end
        end
        if (i_cmd.probe_run && walk_done) begin
            case (i_cmd.walk_kind)
                WALK_SELF: begin
                    r_self_hit  <= e_hit;
                    r_self_full <= e_exh;
                    r_self_slot <= r_chk_addr;
                end
                WALK_LEFT: begin
                    r_lleft <= e_hit ? rd_len : '0;
                end
                WALK_RIGHT: begin
                    r_lright <= e_hit ? rd_len : '0;
                end
                WALK_LOW: begin
                    r_low_hit  <= e_hit;
                    r_low_slot <= r_chk_addr;
                end
                WALK_UP: begin
                    r_up_hit  <= e_hit;
                    r_up_slot <= r_chk_addr;
                end
                default: begin
                    r_self_hit <= r_self_hit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_best     <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= clr_next;
                r_best     <= '0;
            end else if (i_cmd.best_update && (total > r_best)) begin
                r_best <= total;
            end
        end
    end

    assign best_ext = CMP_W'(r_best);
    assign best_sat = (best_ext > CMP_W'(OUT_MAX)) ? OUT_MAX : best_ext[10:0];
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.longest_run   <= best_sat;
            r_out.was_duplicate <= r_self_hit;
            r_out.table_full    <= r_self_full;
        end
    end

    assign o_data  = r_out;
    assign o_valid = r_out_valid;

    always_comb begin
        o_stat.clr_last  = (r_clr_addr == SLOT_W'(TABLE_ENTRIES - 1));
        o_stat.hash_done = hash_done;
        o_stat.walk_done = walk_done;
        o_stat.self_hit  = r_self_hit;
        o_stat.self_full = r_self_full;
        o_stat.key_min   = (item_key == KEY_MIN);
        o_stat.key_max   = (item_key == KEY_MAX);
        o_stat.lleft_nz  = (r_lleft != '0);
        o_stat.lright_nz = (r_lright != '0);
        o_stat.low_write = (r_lleft != '0) && r_low_hit;
        o_stat.up_write  = (r_lright != '0) && r_up_hit;
        o_stat.out_free  = out_free;
    end

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result word loaded over one not yet taken");

    a_best_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.clr_step |=> (r_best >= $past(r_best)))
        else $error("longest run decreased without a clear");

    // The probe count is only meaningful once a walk has started reading.
    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> (r_chk_cnt <= CNT_W'(PROBE_LIM - 1)))
        else $error("probe count ran past the probe window");
`endif

endmodule
`default_nettype wire

// File: design/lcrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Run tracker controller
// Sequences the clearing pass, the table walks for a key and its neighbors,
// the endpoint writes and the hand-off of the result word.
// ----------------------------------------------------------------------------
module lcrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_start_set,
    output logic            o_stall,
    output lcrt_pkg::t_cmd  o_cmd,
    input  lcrt_pkg::t_stat i_stat
);
    import lcrt_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_LAUNCH = 10'b00_0000_0100,
        S_HASH   = 10'b00_0000_1000,
        S_PROBE  = 10'b00_0001_0000,
        S_NEXT   = 10'b00_0010_0000,
        S_WR_SELF = 10'b00_0100_0000,
        S_WR_LOW = 10'b00_1000_0000,
        S_WR_UP  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_walk  r_walk;
    t_walk  n_walk;
    logic   r_held;
    logic   n_held;
    logic   launch;
    t_walk  launch_kind;

    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_held      = r_held;
        launch      = 1'b0;
        launch_kind = WALK_SELF;
        o_cmd       = '0;
        o_cmd.walk_kind = r_walk;
        o_stall     = 1'b1;

        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_held  = 1'b0;
                    n_state = r_held ? S_LAUNCH : S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_start_set) begin
                        n_held  = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: begin
                launch      = 1'b1;
                launch_kind = WALK_SELF;
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.probe_start = 1'b1;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.probe_run = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                // The run below the key is found first, then the run above it,
                // then the far end of each run that exists.
                case (r_walk)
                    WALK_SELF: begin
                        if (i_stat.self_hit || i_stat.self_full) begin
                            n_state = S_DONE;
                        end else if (!i_stat.key_min) begin
                            launch      = 1'b1;
                            launch_kind = WALK_LEFT;
                        end else if (!i_stat.key_max) begin
                            launch      = 1'b1;
                            launch_kind = WALK_RIGHT;
                        end else begin
                            n_state = S_WR_SELF;
                        end
                    end
                    WALK_LEFT: begin
                        if (!i_stat.key_max) begin
                            launch      = 1'b1;
                            launch_kind = WALK_RIGHT;
                        end else if (i_stat.lleft_nz) begin
                            launch      = 1'b1;
                            launch_kind = WALK_LOW;
                        end else begin
                            n_state = S_WR_SELF;
                        end
                    end
                    WALK_RIGHT: begin
                        if (i_stat.lleft_nz) begin
                            launch      = 1'b1;
                            launch_kind = WALK_LOW;
                        end else if (i_stat.lright_nz) begin
                            launch      = 1'b1;
                            launch_kind = WALK_UP;
                        end else begin
                            n_state = S_WR_SELF;
                        end
                    end
                    WALK_LOW: begin
                        if (i_stat.lright_nz) begin
                            launch      = 1'b1;
                            launch_kind = WALK_UP;
                        end else begin
                            n_state = S_WR_SELF;
                        end
                    end
                    WALK_UP: begin
                        n_state = S_WR_SELF;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WR_SELF: begin
                o_cmd.wr_sel      = WR_SELF;
                o_cmd.best_update = 1'b1;
                if (i_stat.low_write) begin
                    n_state = S_WR_LOW;
                end else if (i_stat.up_write) begin
                    n_state = S_WR_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WR_LOW: begin
                o_cmd.wr_sel = WR_LOW;
                n_state = i_stat.up_write ? S_WR_UP : S_DONE;
            end
            S_WR_UP: begin
                o_cmd.wr_sel = WR_UP;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (launch) begin
            o_cmd.walk_start = 1'b1;
            o_cmd.walk_kind  = launch_kind;
            n_walk           = launch_kind;
            n_state          = S_HASH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_walk  <= WALK_SELF;
            r_held  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            r_held  <= n_held;
        end
    end

endmodule
`default_nettype wire
